// ===== hdl/rmd_pkg.sv =====
// rmd_pkg: shared types and constants for the rgba mip level downsampler
// used by rmd_front, rmd_back and the top level; depends on nothing
`timescale 1ns / 1ps

package rmd_pkg;

  localparam int PIXEL_W           = 32;
  localparam int LANE_W            = 9;
  localparam int PAIR_W            = 36;
  localparam int CFG_W             = 12;
  localparam int CFG_INDEX_W       = 2;
  localparam int ROW_W             = 11;
  localparam int MAX_HEIGHT        = 2048;
  localparam int DEFAULT_MAX_WIDTH = 2048;
  localparam int QUEUE_DEPTH       = 4;

  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;

  // what the back part does with one horizontal pair sum
  typedef enum logic [1:0] {
    OP_WRITE,
    OP_SELF,
    OP_READ
  } op_t;

  typedef struct packed {
    logic [PAIR_W-1:0] pair;
    op_t               op;
    logic              last;
  } work_t;

endpackage

// ===== hdl/rmd_ram.sv =====
// rmd_ram: generic single port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module rmd_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== hdl/rmd_fifo.sv =====
// rmd_fifo: small register queue with occupancy count
// no dependencies
`timescale 1ns / 1ps

module rmd_fifo #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4,
  parameter int CNTW  = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty,
  output logic             full,
  output logic [CNTW-1:0]  count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic             wr_en;
  logic             rd_en;

  assign empty = (count == '0);
  assign full  = (32'(count) == DEPTH);
  assign wr_en = push && !full;
  assign rd_en = pop && !empty;
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr_en) begin
        wptr <= (32'(wptr) == DEPTH - 1) ? '0 : wptr + 1'b1;
      end
      if (rd_en) begin
        rptr <= (32'(rptr) == DEPTH - 1) ? '0 : rptr + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hdl/rmd_front.sv =====
// rmd_front: config registers, raster counters and horizontal pairing
// depends on rmd_pkg; feeds work words to the back part through a queue
`timescale 1ns / 1ps

module rmd_front #(
  parameter int MAX_WIDTH = rmd_pkg::DEFAULT_MAX_WIDTH,
  parameter int AW        = (MAX_WIDTH / 2 > 1) ? $clog2(MAX_WIDTH / 2) : 1
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  input  logic [rmd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rmd_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            accept,
  input  logic [rmd_pkg::PIXEL_W-1:0]     pixel_rgba,
  output logic                            work_valid,
  output rmd_pkg::work_t                  work,
  output logic [AW-1:0]                   work_idx
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int EW = $clog2(MAX_WIDTH + 1);

  logic [rmd_pkg::CFG_W-1:0]  source_width;
  logic [rmd_pkg::CFG_W-1:0]  source_height;
  logic [CW-1:0]              column_count;
  logic [rmd_pkg::ROW_W-1:0]  row_count;
  logic [rmd_pkg::PAIR_W-1:0] pair_sum;

  logic [EW-1:0]              eff_w;
  logic [rmd_pkg::CFG_W-1:0]  eff_h;
  logic                       w_one;
  logic                       h_one;
  logic [EW-1:0]              nw;
  logic [rmd_pkg::CFG_W-1:0]  nh;
  logic                       col_last;
  logic                       row_last;
  logic [rmd_pkg::PAIR_W-1:0] px;
  logic [rmd_pkg::PAIR_W-1:0] pair;
  logic                       have_pair;
  logic                       keep_even;
  logic [AW-1:0]              idx;
  logic [rmd_pkg::ROW_W-1:0]  oy;

  function automatic logic [rmd_pkg::PAIR_W-1:0] spread_lanes(
    input logic [rmd_pkg::PIXEL_W-1:0] p);
    logic [rmd_pkg::PAIR_W-1:0] r;
    r = '0;
    for (int ch = 0; ch < 4; ch++) begin
      r[rmd_pkg::LANE_W*ch +: rmd_pkg::LANE_W] = {1'b0, p[8*ch +: 8]};
    end
    return r;
  endfunction

  function automatic logic [rmd_pkg::PAIR_W-1:0] add_lanes(
    input logic [rmd_pkg::PAIR_W-1:0] a, input logic [rmd_pkg::PAIR_W-1:0] b);
    logic [rmd_pkg::PAIR_W-1:0] r;
    r = '0;
    for (int ch = 0; ch < 4; ch++) begin
      r[rmd_pkg::LANE_W*ch +: rmd_pkg::LANE_W] =
        a[rmd_pkg::LANE_W*ch +: rmd_pkg::LANE_W] + b[rmd_pkg::LANE_W*ch +: rmd_pkg::LANE_W];
    end
    return r;
  endfunction

  // clamp the programmed size into the supported range
  always_comb begin
    if (source_width == '0) begin
      eff_w = EW'(1);
    end else if (32'(source_width) > MAX_WIDTH) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = EW'(source_width);
    end
    if (source_height == '0) begin
      eff_h = rmd_pkg::CFG_W'(1);
    end else if (32'(source_height) > rmd_pkg::MAX_HEIGHT) begin
      eff_h = rmd_pkg::CFG_W'(rmd_pkg::MAX_HEIGHT);
    end else begin
      eff_h = source_height;
    end
  end

  assign w_one    = (eff_w == EW'(1));
  assign h_one    = (eff_h == rmd_pkg::CFG_W'(1));
  assign nw       = w_one ? EW'(1) : (eff_w >> 1);
  assign nh       = h_one ? rmd_pkg::CFG_W'(1) : (eff_h >> 1);
  assign col_last = (32'(column_count) + 32'd1 >= 32'(eff_w));
  assign row_last = (32'(row_count) + 32'd1 >= 32'(eff_h));
  assign px       = spread_lanes(pixel_rgba);

  always_comb begin
    pair      = add_lanes(pair_sum, px);
    have_pair = 1'b0;
    keep_even = 1'b0;
    idx       = '0;
    if (w_one) begin
      pair      = add_lanes(px, px);
      have_pair = 1'b1;
    end else if (column_count[0]) begin
      have_pair = 1'b1;
      idx       = AW'(column_count >> 1);
    end else if (!col_last) begin
      keep_even = 1'b1;
    end
    oy = h_one ? '0 : (row_count >> 1);

    work.pair  = pair;
    work.last  = (32'(idx) + 32'd1 == 32'(nw)) && (32'(oy) + 32'd1 == 32'(nh));
    work.op    = rmd_pkg::OP_WRITE;
    work_valid = 1'b0;
    if (h_one) begin
      work.op    = rmd_pkg::OP_SELF;
      work_valid = accept && have_pair;
    end else if (row_count[0]) begin
      work.op    = rmd_pkg::OP_READ;
      work_valid = accept && have_pair;
    end else if (!row_last) begin
      work_valid = accept && have_pair;
    end
    work_idx = idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= rmd_pkg::CFG_W'(1);
      source_height <= rmd_pkg::CFG_W'(1);
      column_count  <= '0;
      row_count     <= '0;
      pair_sum      <= '0;
    end else if (cfg_valid && (cfg_index == rmd_pkg::REG_SOURCE_WIDTH ||
                               cfg_index == rmd_pkg::REG_SOURCE_HEIGHT)) begin
      if (cfg_index == rmd_pkg::REG_SOURCE_WIDTH) begin
        source_width <= cfg_data;
      end else begin
        source_height <= cfg_data;
      end
      column_count <= '0;
      row_count    <= '0;
      pair_sum     <= '0;
    end else if (accept) begin
      if (keep_even) begin
        pair_sum <= px;
      end
      if (col_last) begin
        column_count <= '0;
        row_count    <= row_last ? '0 : row_count + 1'b1;
      end else begin
        column_count <= column_count + 1'b1;
      end
    end
  end

endmodule

// ===== hdl/rmd_back.sv =====
// rmd_back: line buffer access and 2x2 rounding average
// depends on rmd_pkg and rmd_ram; pushes finished pixels into the output queue
`timescale 1ns / 1ps

module rmd_back #(
  parameter int MAX_WIDTH = rmd_pkg::DEFAULT_MAX_WIDTH,
  parameter int AW        = (MAX_WIDTH / 2 > 1) ? $clog2(MAX_WIDTH / 2) : 1,
  parameter int CNTW      = $clog2(rmd_pkg::QUEUE_DEPTH + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        mid_empty,
  input  rmd_pkg::work_t              mid_work,
  input  logic [AW-1:0]               mid_idx,
  output logic                        mid_pop,
  input  logic [CNTW-1:0]             out_count,
  output logic                        out_push,
  output logic [rmd_pkg::PIXEL_W-1:0] out_pixel,
  output logic                        out_last
);

  localparam int LINE_DEPTH = MAX_WIDTH / 2;

  logic                       s1_valid;
  rmd_pkg::op_t               s1_op;
  logic [rmd_pkg::PAIR_W-1:0] s1_pair;
  logic                       s1_last;
  logic [rmd_pkg::PAIR_W-1:0] rdata;
  logic [rmd_pkg::PAIR_W-1:0] below;

  function automatic logic [rmd_pkg::PIXEL_W-1:0] average_lanes(
    input logic [rmd_pkg::PAIR_W-1:0] a, input logic [rmd_pkg::PAIR_W-1:0] b);
    logic [rmd_pkg::PIXEL_W-1:0] r;
    logic [10:0]                 s;
    r = '0;
    for (int ch = 0; ch < 4; ch++) begin
      s = 11'(a[rmd_pkg::LANE_W*ch +: rmd_pkg::LANE_W])
        + 11'(b[rmd_pkg::LANE_W*ch +: rmd_pkg::LANE_W]) + 11'd2;
      r[8*ch +: 8] = s[9:2];
    end
    return r;
  endfunction

  // credit check: every word in flight has a place waiting in the output queue
  assign mid_pop = !mid_empty &&
                   (32'(out_count) + 32'(s1_valid) < rmd_pkg::QUEUE_DEPTH);

  rmd_ram #(
    .WIDTH (rmd_pkg::PAIR_W),
    .DEPTH (LINE_DEPTH),
    .AW    (AW)
  ) u_line (
    .clk   (clk),
    .we    (mid_pop && mid_work.op == rmd_pkg::OP_WRITE),
    .re    (mid_pop && mid_work.op == rmd_pkg::OP_READ),
    .addr  (mid_idx),
    .wdata (mid_work.pair),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= mid_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_pop) begin
      s1_op   <= mid_work.op;
      s1_pair <= mid_work.pair;
      s1_last <= mid_work.last;
    end
  end

  always_comb begin
    below    = s1_pair;
    out_push = 1'b0;
    case (s1_op)
      rmd_pkg::OP_READ: begin
        below    = rdata;
        out_push = s1_valid;
      end
      rmd_pkg::OP_SELF: begin
        out_push = s1_valid;
      end
      default: begin
        out_push = 1'b0;
      end
    endcase
    out_pixel = average_lanes(s1_pair, below);
    out_last  = s1_last;
  end

endmodule

// ===== hdl/rgba_mip_level_downsampler.sv =====
// rgba_mip_level_downsampler: top level of the 2x2 box filter mip downsampler
// depends on rmd_pkg, rmd_front, rmd_fifo, rmd_back and rmd_ram
//
// usage:
//   source pixels enter in raster order through push/full; a word is taken at
//   a rising edge with push high and full low. downsampled pixels leave in
//   raster order through empty/pop; the head word sits on out_rgba and
//   last_of_level while empty is low and is taken when pop is high.
//   source_width and source_height are written through cfg_valid/cfg_ready
//   (cfg_ready is always high); a write to either size restarts the level.
//   write only while the block is idle.
// throughput: one source pixel per clock while full is low. the front
//   counters and the single port line buffer each handle one word a cycle.
// path: a pixel that completes a 2x2 block passes the work queue, the line
//   buffer read and the output queue, in that order, before it shows.
// stall: when pop stays low the output queue fills, the back part stops
//   issuing, the 4-deep work queue fills and full rises.
// reset: both sizes return to 1, counters to the first pixel, queues empty.
//   the line buffer needs no clearing since each entry is written before use.
`timescale 1ns / 1ps

module rgba_mip_level_downsampler #(
  parameter int MAX_WIDTH = rmd_pkg::DEFAULT_MAX_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic [rmd_pkg::PIXEL_W-1:0]     pixel_rgba,
  output logic                            empty,
  input  logic                            pop,
  output logic [rmd_pkg::PIXEL_W-1:0]     out_rgba,
  output logic                            last_of_level,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rmd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rmd_pkg::CFG_W-1:0]       cfg_data
);

  localparam int AW     = (MAX_WIDTH / 2 > 1) ? $clog2(MAX_WIDTH / 2) : 1;
  localparam int CNTW   = $clog2(rmd_pkg::QUEUE_DEPTH + 1);
  localparam int WORK_W = $bits(rmd_pkg::work_t) + AW;
  localparam int OUT_W  = rmd_pkg::PIXEL_W + 1;

  logic                        accept;
  logic                        work_valid;
  rmd_pkg::work_t              work;
  logic [AW-1:0]               work_idx;
  rmd_pkg::work_t              mid_work;
  logic [AW-1:0]               mid_idx;
  logic                        mid_empty;
  logic                        mid_full;
  logic                        mid_pop;
  logic [CNTW-1:0]             mid_count;
  logic                        out_push;
  logic [rmd_pkg::PIXEL_W-1:0] out_pixel;
  logic                        out_last;
  logic                        out_full;
  logic [CNTW-1:0]             out_count;

  assign cfg_ready = 1'b1;
  assign full      = mid_full;
  assign accept    = push && !mid_full;

  rmd_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .AW        (AW)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .pixel_rgba (pixel_rgba),
    .work_valid (work_valid),
    .work       (work),
    .work_idx   (work_idx)
  );

  rmd_fifo #(
    .WIDTH (WORK_W),
    .DEPTH (rmd_pkg::QUEUE_DEPTH),
    .CNTW  (CNTW)
  ) u_mid (
    .clk   (clk),
    .rst   (rst),
    .push  (work_valid),
    .wdata ({work, work_idx}),
    .pop   (mid_pop),
    .rdata ({mid_work, mid_idx}),
    .empty (mid_empty),
    .full  (mid_full),
    .count (mid_count)
  );

  rmd_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .AW        (AW),
    .CNTW      (CNTW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .mid_empty (mid_empty),
    .mid_work  (mid_work),
    .mid_idx   (mid_idx),
    .mid_pop   (mid_pop),
    .out_count (out_count),
    .out_push  (out_push),
    .out_pixel (out_pixel),
    .out_last  (out_last)
  );

  rmd_fifo #(
    .WIDTH (OUT_W),
    .DEPTH (rmd_pkg::QUEUE_DEPTH),
    .CNTW  (CNTW)
  ) u_out (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .wdata ({out_last, out_pixel}),
    .pop   (pop),
    .rdata ({last_of_level, out_rgba}),
    .empty (empty),
    .full  (out_full),
    .count (out_count)
  );

  // the credit check must leave room for every finished word
  a_out_room: assert property (@(posedge clk) disable iff (rst)
    out_push |-> !out_full && 32'(out_count) < rmd_pkg::QUEUE_DEPTH)
    else $error("output queue overrun");

  // the front never pushes into a full work queue
  a_mid_room: assert property (@(posedge clk) disable iff (rst)
    work_valid |-> !mid_full)
    else $error("work queue overrun");

  // the back only issues what the work queue holds
  a_mid_pop: assert property (@(posedge clk) disable iff (rst)
    mid_pop |-> mid_count != '0)
    else $error("work queue underrun");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> empty && !full)
    else $error("queues not empty after reset");

endmodule
